// ----- design/olir_pkg.sv -----
// package with shared constants and types for the ordered list block
`timescale 1ns / 1ps
`default_nettype none

package olir_pkg;

    localparam int CAPACITY    = 16;
    localparam int KEY_BITS    = 31;
    localparam int HANDLE_BITS = 16;
    localparam int COUNT_BITS  = $clog2(CAPACITY + 1);

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_REMOVE = 1'b1;

    localparam logic [1:0] ST_INSERTED  = 2'd0;
    localparam logic [1:0] ST_REMOVED   = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [1:0] ST_FULL      = 2'd3;

    typedef logic [KEY_BITS-1:0]    key_t;
    typedef logic [HANDLE_BITS-1:0] handle_t;
    typedef logic [COUNT_BITS-1:0]  count_t;

    // broadcast control from the top level to every cell
    typedef struct packed {
        logic insert;
        logic remove;
        key_t key;
    } cell_ctrl_t;

endpackage

`default_nettype wire

// ----- design/olir_cell.sv -----
// one list cell: holds an entry, compares its key and shifts with its neighbors
`timescale 1ns / 1ps
`default_nettype none

module olir_cell (
    input  wire                      clk,
    input  olir_pkg::cell_ctrl_t     ctrl,
    input  wire                      occupied,
    input  olir_pkg::key_t           prev_key,
    input  olir_pkg::handle_t        prev_handle,
    input  olir_pkg::key_t           next_key,
    input  olir_pkg::handle_t        next_handle,
    input  wire                      found_in,
    input  olir_pkg::handle_t        sel_handle_in,
    output olir_pkg::key_t           key,
    output olir_pkg::handle_t        handle,
    output logic                     found_out,
    output olir_pkg::handle_t        sel_handle_out
);

    olir_pkg::key_t    key_reg;
    olir_pkg::handle_t handle_reg;
    logic              hit;
    logic              first_hit;
    logic              close_gap;

    assign hit            = ctrl.remove && occupied && (key_reg == ctrl.key);
    assign first_hit      = hit && !found_in;
    assign found_out      = found_in || hit;
    assign close_gap      = ctrl.remove && found_out;
    assign sel_handle_out = first_hit ? handle_reg : sel_handle_in;

    assign key    = key_reg;
    assign handle = handle_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.insert)
        begin
            key_reg    <= prev_key;
            handle_reg <= prev_handle;
        end
        else if (close_gap)
        begin
            key_reg    <= next_key;
            handle_reg <= next_handle;
        end
    end

endmodule

`default_nettype wire

// ----- design/ordered_list_insert_remove_by_key.sv -----
// top level of the ordered list with insert at front and remove by key
//
// usage: one stream of command words in, one result word out for each
// command. an insert word places (key, handle) at the front of the list
// and pushes the held entries back one cell; a remove word finds the
// frontmost entry with an equal key, returns its handle and closes the gap.
// inserts into a full list are dropped and reported as full; a remove with
// no match reports not found and leaves the list as it is.
//
// timing: a word is processed in the cycle it is accepted and its result
// stands in the output register in the next cycle. one word per cycle is
// sustained while the receiver takes results: the row of cells compares
// all keys at once and moves every entry by one cell in that same cycle.
// the match search ripples through the cell chain, which sets the clock period.
// stall: while the result register is full and the receiver holds tready
// low, s_axis_tready is low and no word is taken.
// reset: rst_n clears the entry count (list empty) and the output valid;
// cell contents are not cleared, only the first count cells are ever read.
`timescale 1ns / 1ps
`default_nettype none

module ordered_list_insert_remove_by_key (
    input  wire         clk,
    input  wire         rst_n,
    // command channel
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [47:0] s_axis_tdata,  // key [30:0], handle [46:31], zero pad
    input  wire         s_axis_tuser,  // command [0]
    // result channel
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [23:0] m_axis_tdata,  // removed_handle [15:0], entry_count [20:16]
    output logic [1:0]  m_axis_tuser   // status [1:0]
);

    localparam int N = olir_pkg::CAPACITY;

    // input word fields
    logic              in_accept;
    logic              in_command;
    olir_pkg::key_t    in_key;
    olir_pkg::handle_t in_handle;

    // list state
    olir_pkg::count_t count_reg;
    olir_pkg::count_t count_next;
    logic             list_full;

    // result register
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [1:0]        status_reg;
    logic [1:0]        status_next;
    olir_pkg::handle_t rem_handle_reg;
    olir_pkg::handle_t rem_handle_next;
    olir_pkg::count_t  out_count_reg;

    // cell chain wiring
    olir_pkg::cell_ctrl_t ctrl;
    olir_pkg::key_t       cell_key    [N];
    olir_pkg::handle_t    cell_handle [N];
    logic                 found_chain [N+1];
    olir_pkg::handle_t    sel_chain   [N+1];

    assign in_command = s_axis_tuser;
    assign in_key     = s_axis_tdata[olir_pkg::KEY_BITS-1:0];
    assign in_handle  = s_axis_tdata[olir_pkg::KEY_BITS +: olir_pkg::HANDLE_BITS];

    // result register is free or being emptied this cycle
    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    assign list_full = (count_reg == olir_pkg::count_t'(N));

    // broadcast control: inserts into a full list touch nothing
    assign ctrl.insert = in_accept && (in_command == olir_pkg::CMD_INSERT) && !list_full;
    assign ctrl.remove = in_accept && (in_command == olir_pkg::CMD_REMOVE);
    assign ctrl.key    = in_key;

    // search chain starts empty at the front
    assign found_chain[0] = 1'b0;
    assign sel_chain[0]   = '0;

    genvar i;
    generate
        for (i = 0; i < N; i++)
        begin : g_cell
            olir_pkg::key_t    prev_key;
            olir_pkg::handle_t prev_handle;
            olir_pkg::key_t    next_key;
            olir_pkg::handle_t next_handle;
            logic              occupied;

            assign occupied = (count_reg > olir_pkg::count_t'(i));

            // front cell takes the new entry, others take their front neighbor
            if (i == 0)
            begin : g_front
                assign prev_key    = in_key;
                assign prev_handle = in_handle;
            end
            else
            begin : g_mid
                assign prev_key    = cell_key[i-1];
                assign prev_handle = cell_handle[i-1];
            end

            // last cell has no back neighbor; its content past the count is unused
            if (i == N - 1)
            begin : g_back
                assign next_key    = cell_key[i];
                assign next_handle = cell_handle[i];
            end
            else
            begin : g_inner
                assign next_key    = cell_key[i+1];
                assign next_handle = cell_handle[i+1];
            end

            olir_cell u_cell (
                .clk            (clk),
                .ctrl           (ctrl),
                .occupied       (occupied),
                .prev_key       (prev_key),
                .prev_handle    (prev_handle),
                .next_key       (next_key),
                .next_handle    (next_handle),
                .found_in       (found_chain[i]),
                .sel_handle_in  (sel_chain[i]),
                .key            (cell_key[i]),
                .handle         (cell_handle[i]),
                .found_out      (found_chain[i+1]),
                .sel_handle_out (sel_chain[i+1])
            );
        end
    endgenerate

    // count update and result word
    always_comb
    begin
        count_next      = count_reg;
        status_next     = status_reg;
        rem_handle_next = rem_handle_reg;
        if (in_accept)
        begin
            rem_handle_next = '0;
            if (in_command == olir_pkg::CMD_INSERT)
            begin
                if (list_full)
                begin
                    status_next = olir_pkg::ST_FULL;
                end
                else
                begin
                    status_next = olir_pkg::ST_INSERTED;
                    count_next  = count_reg + olir_pkg::count_t'(1);
                end
            end
            else if (found_chain[N])
            begin
                status_next     = olir_pkg::ST_REMOVED;
                rem_handle_next = sel_chain[N];
                count_next      = count_reg - olir_pkg::count_t'(1);
            end
            else
            begin
                status_next = olir_pkg::ST_NOT_FOUND;
            end
        end
    end

    assign out_valid_next = in_accept || (out_valid_reg && !m_axis_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload of the result register
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            status_reg     <= status_next;
            rem_handle_reg <= rem_handle_next;
            out_count_reg  <= count_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = status_reg;
    assign m_axis_tdata  = {3'b000, out_count_reg, rem_handle_reg};

endmodule

`default_nettype wire
